// ----- rtl/afca_pkg.sv -----
// Shared types and constants for the airflow curve averaging block.
// Used by afca_curve_regs, afca_serial_mul, afca_serial_div and the top level.
// No dependencies.
package afca_pkg;

	localparam int CURVE_POINTS = 8;
	localparam int NUM_REGS     = 8;

	localparam int MV_W    = 16;
	localparam int FLOW_W  = 20;
	localparam int REG_W   = MV_W + FLOW_W;
	localparam int SUM_W   = 28;
	localparam int TALLY_W = 8;
	localparam int PROD_W  = FLOW_W + MV_W;
	localparam int IDX_W   = $clog2(NUM_REGS);

	localparam int MUL_STEPS = MV_W;
	localparam int DIV_STEPS = FLOW_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
	localparam logic [IDX_W-1:0]   LAST_SEG  = IDX_W'(CURVE_POINTS - 2);

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_SYNC   = 1'b1;

	localparam logic [REG_W-1:0] BP_RESET [NUM_REGS] = '{
		36'd1556088832, 36'd1658849792, 36'd1876954880, 36'd2384469504,
		36'd3027254272, 36'd3802167296, 36'd4690344448, 36'd5181108736
	};

	// One curve breakpoint as it sits in a register
	typedef struct packed {
		logic [MV_W-1:0]   mv;
		logic [FLOW_W-1:0] flow;
	} point_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_SEARCH,
		ST_MUL,
		ST_DIV_SLOPE,
		ST_ACCUM,
		ST_DIV_MEAN,
		ST_OUT
	} state_t;

endpackage

// ----- rtl/airflow_curve_average_top.sv -----
// Airflow curve averaging top level: breakpoint search, serial interpolation,
// window accumulation and mean output. Depends on afca_pkg and all afca_* units.
// A sample stalls the input, unless the window is full, while point 0 is read, the segments are
// searched, the multiplier and divider run where needed and the flow is accumulated. A sync stalls
// it while the divider forms the mean (skipped when the window is empty) and while it waits for the output register.
// Reset restores the default curve and clears sum, count, drop flag and output valid.
module airflow_curve_average_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [afca_pkg::IDX_W-1:0]     cfg_index,
	input  logic [afca_pkg::REG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic [afca_pkg::MV_W-1:0]      sensor_millivolts,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [afca_pkg::FLOW_W-1:0]    mean_flow,
	output logic [afca_pkg::TALLY_W-1:0]   samples_used,
	output logic                           window_empty,
	output logic                           window_overflow
);

	afca_pkg::state_t                 state_q, state_d;
	logic                             in_acc;

	logic [afca_pkg::IDX_W-1:0]       idx_q;
	logic [afca_pkg::IDX_W-1:0]       rd_idx;
	afca_pkg::point_t                 pt;

	logic [afca_pkg::MV_W-1:0]        mv_q;
	logic [afca_pkg::MV_W-1:0]        prev_x_q;
	logic [afca_pkg::FLOW_W-1:0]      prev_y_q;
	logic [afca_pkg::MV_W-1:0]        dx_q;
	logic                             neg_q;
	logic [afca_pkg::FLOW_W-1:0]      flow_q;
	logic [afca_pkg::FLOW_W-1:0]      mean_q;

	logic [afca_pkg::SUM_W-1:0]       sum_q;
	logic [afca_pkg::TALLY_W-1:0]     tally_q;
	logic                             dropped_q;

	logic                             out_valid_q;
	logic [afca_pkg::FLOW_W-1:0]      out_mean_q;
	logic [afca_pkg::TALLY_W-1:0]     out_tally_q;
	logic                             out_empty_q;
	logic                             out_ovf_q;

	logic                             seg_hit;
	logic                             dy_neg;
	logic [afca_pkg::FLOW_W-1:0]      dy;
	logic                             mul_start, mul_done;
	logic [afca_pkg::PROD_W-1:0]      product;
	logic                             div_start, div_done;
	logic [afca_pkg::PROD_W-1:0]      div_num;
	logic [afca_pkg::MV_W-1:0]        div_den;
	logic [afca_pkg::FLOW_W-1:0]      quotient;
	logic                             out_free;

	assign in_stall = (state_q != afca_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Read point 0 first, then point idx+1 during the search
	assign rd_idx = (state_q == afca_pkg::ST_SEARCH) ? idx_q + 1'b1 : '0;

	afca_curve_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_idx    (rd_idx),
		.rd_point  (pt)
	);

	// Segment found and its flow rise or fall
	assign seg_hit = (mv_q < pt.mv);
	assign dy_neg  = (pt.flow < prev_y_q);
	assign dy      = dy_neg ? prev_y_q - pt.flow : pt.flow - prev_y_q;

	afca_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (dy),
		.mplier  (mv_q - prev_x_q),
		.done    (mul_done),
		.product (product)
	);

	// Divider serves the slope and the window mean
	assign div_num = (state_q == afca_pkg::ST_MUL) ? product
		: {{(afca_pkg::PROD_W - afca_pkg::SUM_W){1'b0}}, sum_q};
	assign div_den = (state_q == afca_pkg::ST_MUL) ? dx_q
		: {{(afca_pkg::MV_W - afca_pkg::TALLY_W){1'b0}}, tally_q};

	afca_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (quotient)
	);

	// Next state and unit starts
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			afca_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (func == afca_pkg::FUNC_SYNC) begin
						if (tally_q == '0) begin
							state_d = afca_pkg::ST_OUT;
						end else begin
							div_start = 1'b1;
							state_d   = afca_pkg::ST_DIV_MEAN;
						end
					end else if (tally_q != afca_pkg::TALLY_MAX) begin
						state_d = afca_pkg::ST_FIRST;
					end
				end
			end
			afca_pkg::ST_FIRST: begin
				state_d = (mv_q <= pt.mv) ? afca_pkg::ST_ACCUM : afca_pkg::ST_SEARCH;
			end
			afca_pkg::ST_SEARCH: begin
				if (seg_hit) begin
					mul_start = 1'b1;
					state_d   = afca_pkg::ST_MUL;
				end else if (idx_q == afca_pkg::LAST_SEG) begin
					state_d = afca_pkg::ST_ACCUM;
				end
			end
			afca_pkg::ST_MUL: begin
				if (mul_done) begin
					div_start = 1'b1;
					state_d   = afca_pkg::ST_DIV_SLOPE;
				end
			end
			afca_pkg::ST_DIV_SLOPE: begin
				if (div_done) begin
					state_d = afca_pkg::ST_ACCUM;
				end
			end
			afca_pkg::ST_ACCUM: begin
				state_d = afca_pkg::ST_IDLE;
			end
			afca_pkg::ST_DIV_MEAN: begin
				if (div_done) begin
					state_d = afca_pkg::ST_OUT;
				end
			end
			afca_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = afca_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = afca_pkg::ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= afca_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Window state: sum, count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			tally_q   <= '0;
			dropped_q <= 1'b0;
		end else if (state_q == afca_pkg::ST_ACCUM) begin
			sum_q   <= sum_q + {{(afca_pkg::SUM_W - afca_pkg::FLOW_W){1'b0}}, flow_q};
			tally_q <= tally_q + 1'b1;
		end else if (state_q == afca_pkg::ST_OUT && out_free) begin
			sum_q     <= '0;
			tally_q   <= '0;
			dropped_q <= 1'b0;
		end else if (in_acc && func == afca_pkg::FUNC_SAMPLE
				&& tally_q == afca_pkg::TALLY_MAX) begin
			dropped_q <= 1'b1;
		end
	end

	// Interpolation datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mv_q <= sensor_millivolts;
		end
		case (state_q)
			afca_pkg::ST_FIRST: begin
				prev_x_q <= pt.mv;
				prev_y_q <= pt.flow;
				flow_q   <= pt.flow;
				idx_q    <= '0;
			end
			afca_pkg::ST_SEARCH: begin
				if (seg_hit) begin
					dx_q  <= pt.mv - prev_x_q;
					neg_q <= dy_neg;
				end else begin
					prev_x_q <= pt.mv;
					prev_y_q <= pt.flow;
					flow_q   <= pt.flow;
					idx_q    <= idx_q + 1'b1;
				end
			end
			afca_pkg::ST_DIV_SLOPE: begin
				if (div_done) begin
					flow_q <= neg_q ? prev_y_q - quotient : prev_y_q + quotient;
				end
			end
			afca_pkg::ST_IDLE: begin
				mean_q <= '0;
			end
			afca_pkg::ST_DIV_MEAN: begin
				if (div_done) begin
					mean_q <= quotient;
				end
			end
			default: begin
				flow_q <= flow_q;
			end
		endcase
	end

	// Output register: hold the transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == afca_pkg::ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == afca_pkg::ST_OUT && out_free) begin
			out_mean_q  <= mean_q;
			out_tally_q <= tally_q;
			out_empty_q <= (tally_q == '0);
			out_ovf_q   <= dropped_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign mean_flow       = out_mean_q;
	assign samples_used    = out_tally_q;
	assign window_empty    = out_empty_q;
	assign window_overflow = out_ovf_q;

endmodule

// ----- rtl/afca_curve_regs.sv -----
// Breakpoint register file: eight 36-bit curve points, one write port,
// one read port. Depends on afca_pkg.
module afca_curve_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [afca_pkg::IDX_W-1:0]    cfg_index,
	input  logic [afca_pkg::REG_W-1:0]    cfg_data,
	input  logic [afca_pkg::IDX_W-1:0]    rd_idx,
	output afca_pkg::point_t              rd_point
);

	logic [afca_pkg::REG_W-1:0] bp_q [afca_pkg::NUM_REGS];

	// Load reset curve, then take writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < afca_pkg::NUM_REGS; k++) begin
				bp_q[k] <= afca_pkg::BP_RESET[k];
			end
		end else if (cfg_we) begin
			bp_q[cfg_index] <= cfg_data;
		end
	end

	// Select one point
	assign rd_point = afca_pkg::point_t'(bp_q[rd_idx]);

endmodule

// ----- rtl/afca_serial_mul.sv -----
// Bit-serial shift-add multiplier: 20-bit multiplicand by 16-bit multiplier,
// one multiplier bit per cycle. Depends on afca_pkg.
module afca_serial_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [afca_pkg::FLOW_W-1:0]    mcand,
	input  logic [afca_pkg::MV_W-1:0]      mplier,
	output logic                           done,
	output logic [afca_pkg::PROD_W-1:0]    product
);

	logic                             busy_q;
	logic                             done_q;
	logic [afca_pkg::MUL_CNT_W-1:0]   cnt_q;
	logic [afca_pkg::PROD_W-1:0]      acc_q;
	logic [afca_pkg::FLOW_W-1:0]      mcand_q;
	logic [afca_pkg::FLOW_W:0]        partial;

	// Add multiplicand into the upper half when the low bit is set
	assign partial = {1'b0, acc_q[afca_pkg::PROD_W-1:afca_pkg::MV_W]}
		+ (acc_q[0] ? {1'b0, mcand_q} : '0);

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == afca_pkg::MUL_CNT_W'(afca_pkg::MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the accumulator right, multiplier bits drain from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			acc_q   <= {{afca_pkg::FLOW_W{1'b0}}, mplier};
		end else if (busy_q) begin
			acc_q <= {partial, acc_q[afca_pkg::MV_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ----- rtl/afca_serial_div.sv -----
// Restoring divider, one quotient bit per cycle, 20-bit quotient.
// The dividend's upper 16 bits must be below the divisor. Depends on afca_pkg.
module afca_serial_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [afca_pkg::PROD_W-1:0]    dividend,
	input  logic [afca_pkg::MV_W-1:0]      divisor,
	output logic                           done,
	output logic [afca_pkg::FLOW_W-1:0]    quotient
);

	logic                             busy_q;
	logic                             done_q;
	logic [afca_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [afca_pkg::MV_W-1:0]        rem_q;
	logic [afca_pkg::MV_W-1:0]        dvs_q;
	logic [afca_pkg::FLOW_W-1:0]      work_q;
	logic [afca_pkg::MV_W:0]          shifted;
	logic [afca_pkg::MV_W:0]          diff;
	logic                             qbit;

	// Trial subtract of the divisor from the shifted remainder
	assign shifted = {rem_q, work_q[afca_pkg::FLOW_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign qbit    = !diff[afca_pkg::MV_W];

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == afca_pkg::DIV_CNT_W'(afca_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift dividend bits in at the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend[afca_pkg::PROD_W-1:afca_pkg::FLOW_W];
			work_q <= dividend[afca_pkg::FLOW_W-1:0];
			dvs_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= qbit ? diff[afca_pkg::MV_W-1:0] : shifted[afca_pkg::MV_W-1:0];
			work_q <= {work_q[afca_pkg::FLOW_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule
